// ===== rtl/u8ws_pkg.sv =====
// u8ws_pkg: types, constants and helper functions for the utf-8 whitespace stripper
// used by u8ws_char, utf8_whitespace_stripper and u8ws_checker; depends on nothing
package u8ws_pkg;

	localparam logic [7:0] ByteNbsp1   = 8'hC2;
	localparam logic [7:0] ByteNbsp2   = 8'hA0;
	localparam logic [7:0] ByteOgham1  = 8'hE1;
	localparam logic [7:0] ByteOgham2  = 8'h9A;
	localparam logic [7:0] ByteGenp1   = 8'hE2;
	localparam logic [7:0] ByteCont80  = 8'h80;
	localparam logic [7:0] ByteCont81  = 8'h81;
	localparam logic [7:0] ByteHairMax = 8'h8A;
	localparam logic [7:0] ByteNnbsp3  = 8'hAF;
	localparam logic [7:0] ByteMmsp3   = 8'h9F;
	localparam logic [7:0] ByteIdeo1   = 8'hE3;

	typedef logic [7:0] byte_t;

	// control state of the character assembler
	typedef struct packed {
		logic [1:0] cnt;
		logic [2:0] clen;
		logic       stopped;
	} asm_state_t;

	// a run of results waiting to be sent
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
		logic            has_bytes;
		logic            str_end;
	} burst_t;

	function automatic logic [2:0] lead_class(input byte_t b);
		logic [2:0] r;
		if (b[7] == 1'b0)             r = 3'd1;
		else if (b[7:5] == 3'b110)    r = 3'd2;
		else if (b[7:4] == 4'b1110)   r = 3'd3;
		else if (b[7:3] == 5'b11110)  r = 3'd4;
		else                          r = 3'd1;
		return r;
	endfunction

	function automatic logic is_space(input logic [3:0][7:0] c, input logic [2:0] n);
		logic r;
		r = 1'b0;
		if (n == 3'd1) begin
			r = (c[0] == 8'h20) || (c[0] == 8'h09) || (c[0] == 8'h0A) ||
			    (c[0] == 8'h0D) || (c[0] == 8'h0B) || (c[0] == 8'h0C);
		end else if (n == 3'd2) begin
			r = (c[0] == ByteNbsp1) && (c[1] == ByteNbsp2);
		end else if (n == 3'd3) begin
			if (c[0] == ByteOgham1 && c[1] == ByteOgham2 && c[2] == ByteCont80)
				r = 1'b1;
			if (c[0] == ByteGenp1 && c[1] == ByteCont80 && c[2] >= ByteCont80 &&
			    c[2] <= ByteHairMax)
				r = 1'b1;
			if (c[0] == ByteGenp1 && c[1] == ByteCont80 && c[2] == ByteNnbsp3)
				r = 1'b1;
			if (c[0] == ByteGenp1 && c[1] == ByteCont81 && c[2] == ByteMmsp3)
				r = 1'b1;
			if (c[0] == ByteIdeo1 && c[1] == ByteCont80 && c[2] == ByteCont80)
				r = 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/u8ws_if.sv =====
// u8ws_in_if / u8ws_out_if: valid/ready channels of the whitespace stripper
// depends on nothing
interface u8ws_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
	modport monitor (input valid, input in_byte, input in_last, input ready);
endinterface

interface u8ws_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       string_end;

	modport source (output valid, output out_byte, output byte_valid, output run_last,
		output string_end, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input run_last,
		input string_end, output ready);
	modport monitor (input valid, input out_byte, input byte_valid, input run_last,
		input string_end, input ready);
endinterface

// ===== rtl/u8ws_char.sv =====
// u8ws_char: combinational character assembler, whitespace test and emit run builder
// depends on u8ws_pkg
module u8ws_char (
	input  u8ws_pkg::asm_state_t st,
	input  logic [2:0][7:0]      pend,
	input  u8ws_pkg::byte_t      in_byte,
	input  logic                 in_last,
	output u8ws_pkg::asm_state_t st_next,
	output logic [2:0][7:0]      pend_next,
	output logic                 burst_load,
	output u8ws_pkg::burst_t     burst
);

	logic [3:0][7:0] c;
	logic [2:0]      total;
	logic [2:0]      n;
	logic            complete;
	logic            hold;
	logic            keep;
	logic            alive;
	logic            zero_hit;
	logic [2:0]      k;

	always_comb begin
		for (int i = 0; i < 3; i++)
			c[i] = (2'(i) < st.cnt) ? pend[i] : in_byte;
		c[3]     = in_byte;
		total    = (st.cnt == 2'd0) ? u8ws_pkg::lead_class(in_byte) : st.clen;
		n        = {1'b0, st.cnt} + 3'd1;
		complete = (n >= total) || (n == 3'd4);
		hold     = !complete && !in_last;
		keep     = complete ? !u8ws_pkg::is_space(c, n) : 1'b1;
	end

	// emit the leading non-zero bytes; a zero byte stops output until the string ends
	always_comb begin
		alive    = keep && !st.stopped;
		zero_hit = 1'b0;
		k        = 3'd0;
		for (int i = 0; i < 4; i++) begin
			if (alive && 3'(i) < n) begin
				if (c[i] == 8'h00) begin
					zero_hit = 1'b1;
					alive    = 1'b0;
				end else begin
					k = k + 3'd1;
				end
			end else begin
				alive = 1'b0;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			pend_next[i] = (hold && st.cnt == 2'(i)) ? in_byte : pend[i];

		if (hold) begin
			st_next.cnt     = st.cnt + 2'd1;
			st_next.clen    = (st.cnt == 2'd0) ? total : st.clen;
			st_next.stopped = st.stopped;
		end else begin
			st_next.cnt     = 2'd0;
			st_next.clen    = 3'd0;
			st_next.stopped = in_last ? 1'b0 : (st.stopped | (keep & zero_hit));
		end

		burst.bytes   = c;
		burst.str_end = in_last;
		if (k == 3'd0) begin
			burst.bytes[0]  = 8'h00;
			burst.cnt       = 3'd1;
			burst.has_bytes = 1'b0;
		end else begin
			burst.cnt       = k;
			burst.has_bytes = 1'b1;
		end
		burst_load = !hold && (in_last || k != 3'd0);
	end

endmodule

// ===== rtl/utf8_whitespace_stripper.sv =====
// utf8_whitespace_stripper: top level of the utf-8 whitespace stripper
// depends on u8ws_pkg, u8ws_if and u8ws_char
//
// data_ch carries one raw byte per item (in_byte) with in_last on the final
// byte of a string. result_ch carries the bytes of every kept character, one
// per item, with run_last on the last byte caused by an input item and
// string_end on the final item of a string. The final input of a string
// always gives at least one item: a bare marker (byte_valid low) if nothing
// else is emitted.
// An input item is registered, then assembled combinationally into a run of 0 to
// 4 results that is loaded into the result register; the first result is
// presented on result_ch from that register.
// Throughput: one input item per cycle unless held as follows; an item that
// only extends a character goes on while a run is being sent, while an item
// that starts a run waits until the last result of the current run is taken.
// A stalled receiver holds the current result stable; an item that starts a
// run then waits in the input register and data_ch.ready drops. Reset clears
// all control state and leaves both channels empty.
module utf8_whitespace_stripper (
	input  logic              clk,
	input  logic              arst_n,
	u8ws_in_if.sink           data_ch,
	u8ws_out_if.source        result_ch
);

	logic                 valid_s1;
	u8ws_pkg::byte_t      byte_s1;
	logic                 last_s1;

	u8ws_pkg::asm_state_t st_q;
	logic [2:0][7:0]      pend_q;
	u8ws_pkg::burst_t     burst_q;
	logic                 burst_valid_q;
	logic [1:0]           idx_q;

	u8ws_pkg::asm_state_t st_next;
	logic [2:0][7:0]      pend_next;
	logic                 burst_load;
	u8ws_pkg::burst_t     burst_new;

	logic                 out_take;
	logic                 at_end;
	logic                 burst_free;
	logic                 s1_go;

	u8ws_char u_char (
		.st         (st_q),
		.pend       (pend_q),
		.in_byte    (byte_s1),
		.in_last    (last_s1),
		.st_next    (st_next),
		.pend_next  (pend_next),
		.burst_load (burst_load),
		.burst      (burst_new)
	);

	assign out_take      = result_ch.valid && result_ch.ready;
	assign at_end        = ({1'b0, idx_q} + 3'd1) == burst_q.cnt;
	assign burst_free    = !burst_valid_q || (out_take && at_end);
	assign s1_go         = valid_s1 && (burst_free || !burst_load);
	assign data_ch.ready = !valid_s1 || s1_go;

	assign result_ch.valid      = burst_valid_q;
	assign result_ch.out_byte   = burst_q.bytes[idx_q];
	assign result_ch.byte_valid = burst_q.has_bytes;
	assign result_ch.run_last   = at_end;
	assign result_ch.string_end = at_end && burst_q.str_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ch.ready) begin
			valid_s1 <= data_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ch.valid && data_ch.ready) begin
			byte_s1 <= data_ch.in_byte;
			last_s1 <= data_ch.in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= '0;
			burst_valid_q <= 1'b0;
			idx_q         <= 2'd0;
		end else begin
			if (s1_go)
				st_q <= st_next;
			if (s1_go && burst_load) begin
				burst_valid_q <= 1'b1;
				idx_q         <= 2'd0;
			end else if (out_take) begin
				if (at_end) begin
					burst_valid_q <= 1'b0;
					idx_q         <= 2'd0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go)
			pend_q <= pend_next;
		if (s1_go && burst_load)
			burst_q <= burst_new;
	end

endmodule

// ===== rtl/u8ws_checker.sv =====
// u8ws_props: port-level assertions for utf8_whitespace_stripper, with its bind
// depends on u8ws_if
module u8ws_props (
	input logic          clk,
	input logic          arst_n,
	u8ws_in_if.sink      data_ch,
	u8ws_out_if.source   result_ch
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && !result_ch.ready |=> result_ch.valid &&
		$stable(result_ch.out_byte) && $stable(result_ch.byte_valid) &&
		$stable(result_ch.run_last) && $stable(result_ch.string_end))
		else $error("result changed while stalled");

	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && !result_ch.byte_valid |->
		result_ch.run_last && result_ch.string_end && result_ch.out_byte == 8'h00)
		else $error("bare marker malformed");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.string_end |-> result_ch.run_last)
		else $error("string end not on last item of a run");

	a_no_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.byte_valid |-> result_ch.out_byte != 8'h00)
		else $error("zero byte emitted");

endmodule

bind utf8_whitespace_stripper u8ws_props u_u8ws_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.data_ch   (data_ch),
	.result_ch (result_ch)
);

// ===== tb/sv/u8ws_checker.sv =====
// u8ws_checker: watches both channels of the utf-8 whitespace stripper, predicts
// the result items of every accepted input item and compares them in order
// depends on u8ws_pkg and u8ws_if
`timescale 1ns / 1ps

module u8ws_checker (
	input  logic          clk,
	input  logic          arst_n,
	u8ws_in_if.monitor    data_ch,
	u8ws_out_if.monitor   result_ch,
	output int            mismatches,
	output int            results_owed,
	output int            strings_seen,
	output int            inputs_seen,
	output int            results_seen
);

	localparam u8ws_pkg::byte_t AsciiSpace = 8'h20;
	localparam u8ws_pkg::byte_t AsciiTab   = 8'h09;
	localparam u8ws_pkg::byte_t AsciiLf    = 8'h0A;
	localparam u8ws_pkg::byte_t AsciiVt    = 8'h0B;
	localparam u8ws_pkg::byte_t AsciiFf    = 8'h0C;
	localparam u8ws_pkg::byte_t AsciiCr    = 8'h0D;

	typedef struct packed {
		u8ws_pkg::byte_t data;
		logic            has_byte;
		logic            run_end;
		logic            str_end;
	} stripped_byte_t;

	stripped_byte_t stripped_q[$];

	// copy of the character assembler
	u8ws_pkg::byte_t char_bytes [3];
	logic [1:0]      char_fill;
	logic [2:0]      char_size;
	logic            muted;

	function automatic logic [2:0] char_span(input u8ws_pkg::byte_t b);
		casez (b)
			8'b0???????: return 3'd1;
			8'b110?????: return 3'd2;
			8'b1110????: return 3'd3;
			8'b11110???: return 3'd4;
			default:     return 3'd1;
		endcase
	endfunction

	function automatic logic blank_char(input u8ws_pkg::byte_t c0, input u8ws_pkg::byte_t c1,
		input u8ws_pkg::byte_t c2, input int n);
		if (n == 1)
			return c0 == AsciiSpace || c0 == AsciiTab || c0 == AsciiLf ||
			       c0 == AsciiVt || c0 == AsciiFf || c0 == AsciiCr;
		if (n == 2)
			return c0 == u8ws_pkg::ByteNbsp1 && c1 == u8ws_pkg::ByteNbsp2;
		if (n == 3)
			return (c0 == u8ws_pkg::ByteOgham1 && c1 == u8ws_pkg::ByteOgham2 &&
			        c2 == u8ws_pkg::ByteCont80) ||
			       (c0 == u8ws_pkg::ByteGenp1 && c1 == u8ws_pkg::ByteCont80 &&
			        ((c2 >= u8ws_pkg::ByteCont80 && c2 <= u8ws_pkg::ByteHairMax) ||
			         c2 == u8ws_pkg::ByteNnbsp3)) ||
			       (c0 == u8ws_pkg::ByteGenp1 && c1 == u8ws_pkg::ByteCont81 &&
			        c2 == u8ws_pkg::ByteMmsp3) ||
			       (c0 == u8ws_pkg::ByteIdeo1 && c1 == u8ws_pkg::ByteCont80 &&
			        c2 == u8ws_pkg::ByteCont80);
		return 1'b0;
	endfunction

	function automatic void predict_strip(input u8ws_pkg::byte_t b, input logic last);
		u8ws_pkg::byte_t seq [4];
		u8ws_pkg::byte_t kept [4];
		int              held;
		int              n;
		int              want;
		int              k;
		logic            done;
		logic            keep;
		stripped_byte_t  r;
		held = char_fill;
		for (int i = 0; i < held; i++)
			seq[i] = char_bytes[i];
		seq[held] = b;
		n = held + 1;
		want = (held == 0) ? char_span(b) : char_size;
		done = (n >= want) || (n >= 4);
		if (!done && !last) begin
			if (held == 0)
				char_size = 3'(want);
			char_bytes[held] = b;
			char_fill = 2'(held + 1);
			return;
		end
		// a fragment cut short by the end of the string is never blank
		keep = done ? !blank_char(seq[0], seq[1], seq[2], n) : 1'b1;
		k = 0;
		if (keep) begin
			for (int i = 0; i < n; i++) begin
				if (muted)
					break;
				if (seq[i] == 8'h00) begin
					muted = 1'b1;
					break;
				end
				kept[k] = seq[i];
				k++;
			end
		end
		char_fill = '0;
		char_size = '0;
		if (last && k == 0) begin
			r = '{data: 8'h00, has_byte: 1'b0, run_end: 1'b1, str_end: 1'b1};
			stripped_q.push_back(r);
		end
		for (int i = 0; i < k; i++) begin
			r = '{data: kept[i], has_byte: 1'b1, run_end: (i == k - 1),
				str_end: last && (i == k - 1)};
			stripped_q.push_back(r);
		end
		if (last)
			muted = 1'b0;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_stripped();
		stripped_byte_t want;
		if (stripped_q.size() == 0) begin
			report_mismatch($sformatf("unexpected item, byte %02h", result_ch.out_byte));
			return;
		end
		want = stripped_q.pop_front();
		if (result_ch.out_byte !== want.data)
			report_mismatch($sformatf("out_byte %02h, want %02h", result_ch.out_byte,
				want.data));
		if (result_ch.byte_valid !== want.has_byte)
			report_mismatch($sformatf("byte_valid %b, want %b", result_ch.byte_valid,
				want.has_byte));
		if (result_ch.run_last !== want.run_end)
			report_mismatch($sformatf("run_last %b, want %b (byte %02h)",
				result_ch.run_last, want.run_end, want.data));
		if (result_ch.string_end !== want.str_end)
			report_mismatch($sformatf("string_end %b, want %b (byte %02h)",
				result_ch.string_end, want.str_end, want.data));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			stripped_q.delete();
			char_fill = '0;
			char_size = '0;
			muted = 1'b0;
		end else begin
			if (data_ch.valid && data_ch.ready) begin
				inputs_seen++;
				if (data_ch.in_last)
					strings_seen++;
				predict_strip(data_ch.in_byte, data_ch.in_last);
			end
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				check_stripped();
			end
		end
		results_owed = stripped_q.size();
	end

endmodule

// ===== tb/sv/utf8_whitespace_stripper_tb.sv =====
// utf8_whitespace_stripper_tb: drives byte strings into the stripper under several
// idling phases and gives the verdict from the checker's mismatch count
// depends on u8ws_pkg, u8ws_if, utf8_whitespace_stripper and u8ws_checker
`timescale 1ns / 1ps

module utf8_whitespace_stripper_tb;

	localparam int              RandomItems  = 340;
	localparam int              DrainCycles  = 8;
	localparam int              QuietLimit   = 1000;
	localparam u8ws_pkg::byte_t AsciiBlanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   rand_items;
	int   quiet_cycles;
	int   mismatches;
	int   results_owed;
	int   strings_seen;
	int   inputs_seen;
	int   results_seen;

	u8ws_pkg::byte_t text_q [$];

	u8ws_in_if  data_ch ();
	u8ws_out_if result_ch ();

	utf8_whitespace_stripper u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_ch   (data_ch),
		.result_ch (result_ch)
	);

	u8ws_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_ch      (data_ch),
		.result_ch    (result_ch),
		.mismatches   (mismatches),
		.results_owed (results_owed),
		.strings_seen (strings_seen),
		.inputs_seen  (inputs_seen),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n)
			result_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((data_ch.valid && data_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= QuietLimit) begin
					$display("timeout after %0d quiet cycles", quiet_cycles);
					$display("FAILURE");
					$finish;
				end
			end
		end
	end

	task automatic send_item(input u8ws_pkg::byte_t b, input logic last);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			data_ch.valid <= 1'b0;
			@(posedge clk);
		end
		data_ch.valid   <= 1'b1;
		data_ch.in_byte <= b;
		data_ch.in_last <= last;
		@(posedge clk);
		while (!data_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_string(input u8ws_pkg::byte_t s [$]);
		for (int i = 0; i < s.size(); i++)
			send_item(s[i], i == s.size() - 1);
	endtask

	task automatic push_lead_and_tail(input int len, input int tail);
		case (len)
			2:       text_q.push_back(8'hC0 | 8'($urandom_range(31)));
			3:       text_q.push_back(8'hE0 | 8'($urandom_range(15)));
			default: text_q.push_back(8'hF0 | 8'($urandom_range(7)));
		endcase
		repeat (tail)
			text_q.push_back(8'h80 | 8'($urandom_range(63)));
	endtask

	// mostly well-formed characters, with blanks, near misses, zeros and junk mixed in
	task automatic make_string();
		int nchars;
		int kind;
		int len;
		text_q.delete();
		nchars = $urandom_range(10, 1);
		repeat (nchars) begin
			kind = $urandom_range(99);
			if (kind < 30) begin
				text_q.push_back(8'($urandom_range(8'h7E, 8'h21)));
			end else if (kind < 42) begin
				text_q.push_back(AsciiBlanks[$urandom_range(5)]);
			end else if (kind < 57) begin
				case ($urandom_range(5))
					0: text_q = {text_q, u8ws_pkg::ByteNbsp1, u8ws_pkg::ByteNbsp2};
					1: text_q = {text_q, u8ws_pkg::ByteOgham1, u8ws_pkg::ByteOgham2,
						u8ws_pkg::ByteCont80};
					2: text_q = {text_q, u8ws_pkg::ByteGenp1, u8ws_pkg::ByteCont80,
						8'(u8ws_pkg::ByteCont80 + $urandom_range(10))};
					3: text_q = {text_q, u8ws_pkg::ByteGenp1, u8ws_pkg::ByteCont80,
						u8ws_pkg::ByteNnbsp3};
					4: text_q = {text_q, u8ws_pkg::ByteGenp1, u8ws_pkg::ByteCont81,
						u8ws_pkg::ByteMmsp3};
					default: text_q = {text_q, u8ws_pkg::ByteIdeo1, u8ws_pkg::ByteCont80,
						u8ws_pkg::ByteCont80};
				endcase
			end else if (kind < 65) begin
				case ($urandom_range(5))
					0: text_q = {text_q, u8ws_pkg::ByteNbsp1, 8'hA1};
					1: text_q = {text_q, u8ws_pkg::ByteGenp1, u8ws_pkg::ByteCont80, 8'h8B};
					2: text_q = {text_q, u8ws_pkg::ByteGenp1, u8ws_pkg::ByteCont81, 8'hA0};
					3: text_q = {text_q, u8ws_pkg::ByteIdeo1, u8ws_pkg::ByteCont80,
						u8ws_pkg::ByteCont81};
					4: text_q = {text_q, u8ws_pkg::ByteOgham1, u8ws_pkg::ByteOgham2,
						u8ws_pkg::ByteCont81};
					default: text_q = {text_q, 8'hC3, u8ws_pkg::ByteNbsp2};
				endcase
			end else if (kind < 77) begin
				len = $urandom_range(4, 2);
				push_lead_and_tail(len, len - 1);
			end else if (kind < 80) begin
				text_q.push_back(8'h00);
			end else if (kind < 88) begin
				if ($urandom_range(1))
					text_q.push_back(8'h80 | 8'($urandom_range(63)));
				else
					text_q.push_back(8'hF8 | 8'($urandom_range(7)));
			end else begin
				text_q.push_back(8'($urandom));
			end
		end
		// character cut short by the end of the string
		if ($urandom_range(99) < 15) begin
			len = $urandom_range(4, 2);
			push_lead_and_tail(len, $urandom_range(len - 2));
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		data_ch.valid      = 1'b0;
		data_ch.in_byte    = 8'h00;
		data_ch.in_last    = 1'b0;
		result_ch.ready    = 1'b0;
		send_idle_pct      = 0;
		recv_stall_pct     = 0;
		rand_items         = 0;
		quiet_cycles       = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ascii blanks only, ending on a blank
		send_string({8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C});
		send_string({u8ws_pkg::ByteNbsp1, u8ws_pkg::ByteNbsp2, u8ws_pkg::ByteGenp1,
			u8ws_pkg::ByteCont80, u8ws_pkg::ByteHairMax});
		// ideographic space, invalid leads, then a zero that mutes the rest
		send_string({u8ws_pkg::ByteIdeo1, u8ws_pkg::ByteCont80, u8ws_pkg::ByteCont80,
			8'hFF, 8'hF8, 8'h80, 8'h00, 8'h41});
		send_string({8'hF0, 8'h9F, 8'h98});
		send_string({8'h7F});
		send_string({8'h00});

		while (rand_items < RandomItems) begin
			case (rand_items * 5 / RandomItems)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
				3: begin send_idle_pct = 38; recv_stall_pct = 38; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			make_string();
			send_string(text_q);
			rand_items += text_q.size();
		end
		data_ch.valid <= 1'b0;
		@(posedge clk);
		wait (results_owed == 0);
		repeat (DrainCycles) @(posedge clk);

		$display("covered %0d strings, %0d bytes in, %0d items out", strings_seen,
			inputs_seen, results_seen);
		$display("idling phases: none, sender, receiver, both; %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== utf8_whitespace_stripper.f =====
rtl/u8ws_pkg.sv
rtl/u8ws_if.sv
rtl/u8ws_char.sv
rtl/utf8_whitespace_stripper.sv
rtl/u8ws_checker.sv
tb/sv/u8ws_checker.sv
tb/sv/utf8_whitespace_stripper_tb.sv
